/* sv/variable_binding_table_core_assert.svh */
// assertion macros for the binding table core
`ifndef VARIABLE_BINDING_TABLE_CORE_ASSERT_SVH
`define VARIABLE_BINDING_TABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define VBT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VBT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define VBT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* sv/vbt_pkg.sv */
// shared types and constants for the binding table
package vbt_pkg;

	localparam int DEF_ENTRIES = 32;

	typedef enum logic [2:0] {
		OP_BIND  = 3'd0,
		OP_CHECK = 3'd1,
		OP_ADD   = 3'd2,
		OP_GET   = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic scan_inc;
		logic hit_set;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic match;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/vbt_req_if.sv */
// request channel: op, label and value
interface vbt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [63:0] label_key;
	logic [63:0] value_high;
	logic [63:0] value_low;

	modport source (output valid, op, label_key, value_high, value_low, input ready);
	modport sink (input valid, op, label_key, value_high, value_low, output ready);
endinterface

/* sv/vbt_rsp_if.sv */
// response channel: status, found value and count
interface vbt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] found_high;
	logic [63:0] found_low;
	logic [5:0]  entry_count;

	modport source (output valid, status, found_high, found_low, entry_count, input ready);
	modport sink (input valid, status, found_high, found_low, entry_count, output ready);
endinterface

/* sv/vbt_ctrl.sv */
// controller: sequences accept, table scan and response
module vbt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  vbt_pkg::dp_status_t  st,
	output vbt_pkg::ctrl_cmd_t   cmd
);
	import vbt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				if (st.scan_end) begin
					state_d = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				if (st.match) begin
					cmd.hit_set = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = S_READ;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* sv/vbt_datapath.sv */
// datapath: entry memories, scan index, count and response register
`include "variable_binding_table_core_assert.svh"
module vbt_datapath #(
	parameter int ENTRIES = vbt_pkg::DEF_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           op,
	input  logic [63:0]          label_key,
	input  logic [63:0]          value_high,
	input  logic [63:0]          value_low,
	input  vbt_pkg::ctrl_cmd_t   cmd,
	output vbt_pkg::dp_status_t  st,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [1:0]           status,
	output logic [63:0]          found_high,
	output logic [63:0]          found_low,
	output logic [5:0]           entry_count
);
	import vbt_pkg::*;

	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int ADDR_W = $clog2(ENTRIES);

	logic [63:0] label_mem [ENTRIES];
	logic [63:0] high_mem  [ENTRIES];
	logic [63:0] low_mem   [ENTRIES];

	logic [2:0]       op_q;
	logic [63:0]      key_q, hi_q, lo_q;
	logic [63:0]      rd_label_q, rd_hi_q, rd_lo_q;
	logic [CNT_W-1:0] idx_q, count_q, count_d;
	logic             hit_q, out_valid_q;
	logic [1:0]       status_q;
	logic [63:0]      found_hi_q, found_lo_q;
	logic [CNT_W+5:0] count_ext;

	logic       needs_scan, full, same, do_insert;
	status_t    status_d;
	logic [63:0] found_hi_d, found_lo_d;

	always_comb begin
		unique case (op_q)
			OP_BIND, OP_CHECK, OP_ADD, OP_GET: needs_scan = 1'b1;
			default:                           needs_scan = 1'b0;
		endcase
	end

	assign st.scan_end = !needs_scan || (idx_q == count_q);
	assign st.match    = (rd_label_q == key_q);
	assign st.out_free = !out_valid_q || rsp_ready;

	assign full = (count_q == CNT_W'(ENTRIES));
	assign same = (rd_hi_q == hi_q) && (rd_lo_q == lo_q);

	always_comb begin
		status_d   = ST_OK;
		found_hi_d = '0;
		found_lo_d = '0;
		do_insert  = 1'b0;
		count_d    = count_q;
		unique case (op_q)
			OP_BIND: begin
				if (hit_q) begin
					status_d = same ? ST_OK : ST_CONFLICT;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			OP_CHECK: begin
				status_d = (hit_q && !same) ? ST_CONFLICT : ST_OK;
			end
			OP_ADD: begin
				if (!hit_q) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						do_insert = 1'b1;
					end
				end
			end
			OP_GET: begin
				if (hit_q) begin
					found_hi_d = rd_hi_q;
					found_lo_d = rd_lo_q;
				end else begin
					status_d = ST_MISSING;
				end
			end
			OP_CLEAR: count_d = '0;
			default: ;
		endcase
		if (do_insert) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	// request word is latched at accept and held through the scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= label_key;
			hi_q  <= value_high;
			lo_q  <= value_low;
		end
	end

	// one read port walks the slots, the write port appends at the count
	always_ff @(posedge clk) begin
		if (cmd.finish && do_insert) begin
			label_mem[count_q[ADDR_W-1:0]] <= key_q;
			high_mem[count_q[ADDR_W-1:0]]  <= hi_q;
			low_mem[count_q[ADDR_W-1:0]]   <= lo_q;
		end
		if (cmd.rd_en) begin
			rd_label_q <= label_mem[idx_q[ADDR_W-1:0]];
			rd_hi_q    <= high_mem[idx_q[ADDR_W-1:0]];
			rd_lo_q    <= low_mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			hit_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.scan_inc) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmd.hit_set) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q   <= status_d;
			found_hi_q <= found_hi_d;
			found_lo_q <= found_lo_d;
		end
	end

	// count is shown masked to the six bits of the word
	assign count_ext   = {6'b0, count_d};
	logic [5:0] count_out_q;
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			count_out_q <= count_ext[5:0];
		end
	end

	assign rsp_valid   = out_valid_q;
	assign status      = status_q;
	assign found_high  = found_hi_q;
	assign found_low   = found_lo_q;
	assign entry_count = count_out_q;

	`VBT_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(ENTRIES), "count above table size")
	`VBT_ASSERT_NEVER(a_idx_bound, clk, arst_n, idx_q > count_q, "scan index past count")
	`VBT_ASSERT_NEVER(a_no_insert_full, clk, arst_n, cmd.finish && do_insert && full, "insert into full table")
	`VBT_ASSERT(a_count_hold, clk, arst_n, !cmd.finish |=> $stable(count_q), "count moved outside finish")
	`VBT_ASSERT(a_finish_when_free, clk, arst_n, cmd.finish |-> st.out_free, "finish while response blocked")

endmodule

/* sv/variable_binding_table_core.sv */
// a scan reads each held slot in turn, then compares it, until a hit or the count is reached;
// clear and unknown ops skip the scan, and the word is registered on leaving the response state
// no new op is taken during a scan; the next op can be accepted once its word is registered,
// while that word still waits, and an untaken word delays the next finish
// reset: count zero, no word pending; slot memories are not cleared and are read only below count
module variable_binding_table_core #(
	parameter int ENTRIES = vbt_pkg::DEF_ENTRIES
) (
	input logic     clk,
	input logic     arst_n,
	vbt_req_if.sink req,
	vbt_rsp_if.source rsp
);
	import vbt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;
	logic       ready;

	assign req.ready = ready;

	vbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.st        (st),
		.cmd       (cmd)
	);

	vbt_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (req.op),
		.label_key   (req.label_key),
		.value_high  (req.value_high),
		.value_low   (req.value_low),
		.cmd         (cmd),
		.st          (st),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.status      (rsp.status),
		.found_high  (rsp.found_high),
		.found_low   (rsp.found_low),
		.entry_count (rsp.entry_count)
	);

endmodule

/* bench/variable_binding_table_core_tb.sv */
// testbench for the binding table core: directed and random ops checked against a local table model
module variable_binding_table_core_tb;
	import vbt_pkg::*;

	localparam int TABLE_SLOTS = DEF_ENTRIES;
	localparam int ITEM_TARGET = 1050;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 16;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] OP_SPARE_LO = 3'(OP_CLEAR + 1);
	localparam logic [2:0] OP_SPARE_HI = 3'h7;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] label_key;
		logic [63:0] value_high;
		logic [63:0] value_low;
		bit          drain_first;
	} binding_op_t;

	typedef struct {
		status_t     status;
		logic [63:0] found_high;
		logic [63:0] found_low;
		logic [5:0]  entry_count;
	} binding_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	vbt_req_if req_ch();
	vbt_rsp_if rsp_ch();

	variable_binding_table_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// local copy of the table
	logic [63:0] tab_label [TABLE_SLOTS];
	logic [63:0] tab_high [TABLE_SLOTS];
	logic [63:0] tab_low [TABLE_SLOTS];
	int held;
	int op_seen [8];
	int status_seen [4];

	binding_op_t pend_q[$];
	binding_op_t on_bus;
	binding_word_t exp_q[$];
	int n_acc;
	int n_words;
	int n_fail;
	int n_holds;
	int burst_left = 1;
	int gap_left;
	int quiet_cycles;

	function automatic status_t store_binding(binding_op_t it);
		if (held >= TABLE_SLOTS)
			return ST_FULL;
		tab_label[held] = it.label_key;
		tab_high[held] = it.value_high;
		tab_low[held] = it.value_low;
		held++;
		return ST_OK;
	endfunction

	function automatic binding_word_t apply_op(binding_op_t it);
		binding_word_t w;
		int slot;
		bit same;
		w.status = ST_OK;
		w.found_high = '0;
		w.found_low = '0;
		slot = -1;
		same = 1'b0;
		for (int i = 0; i < held; i++)
			if (slot < 0 && tab_label[i] == it.label_key)
				slot = i;
		if (slot >= 0)
			same = tab_high[slot] == it.value_high && tab_low[slot] == it.value_low;
		case (it.op)
			OP_BIND: begin
				if (slot >= 0)
					w.status = same ? ST_OK : ST_CONFLICT;
				else
					w.status = store_binding(it);
			end
			OP_CHECK: begin
				if (slot >= 0 && !same)
					w.status = ST_CONFLICT;
			end
			OP_ADD: begin
				if (slot < 0)
					w.status = store_binding(it);
			end
			OP_GET: begin
				if (slot >= 0) begin
					w.found_high = tab_high[slot];
					w.found_low = tab_low[slot];
				end else begin
					w.status = ST_MISSING;
				end
			end
			OP_CLEAR: held = 0;
			default: ;
		endcase
		w.entry_count = 6'(held);
		op_seen[it.op]++;
		status_seen[w.status]++;
		return w;
	endfunction

	task automatic report_fail(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("mismatch %0d at %0t: %s", n_fail, $time, msg);
	endtask

	// sender: bursts of words with random gaps, or a wait for a full drain
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				exp_q.push_back(apply_op(on_bus));
				n_acc++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pend_q.size() != 0 &&
						(!pend_q[0].drain_first || exp_q.size() == 0)) begin
					on_bus = pend_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.op <= on_bus.op;
					req_ch.label_key <= on_bus.label_key;
					req_ch.value_high <= on_bus.value_high;
					req_ch.value_low <= on_bus.value_low;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus long holds while the sender keeps offering
	rx_mode_t rx_mode = RX_OPEN;
	int mode_left;
	int hold_left;
	int next_hold = 200;
	int phase;

	always @(posedge clk) begin
		if (arst_n) begin
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (n_acc >= next_hold && req_ch.valid) begin
				hold_left = HOLD_CYCLES;
				next_hold += 400;
				n_holds++;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_MOSTLY));
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_OPEN: rsp_ch.ready <= 1'b1;
					RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: rsp_ch.ready <= (phase % 5 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		binding_word_t want;
		binding_word_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = status_t'(rsp_ch.status);
			got.found_high = rsp_ch.found_high;
			got.found_low = rsp_ch.found_low;
			got.entry_count = rsp_ch.entry_count;
			n_words++;
			if (exp_q.size() == 0) begin
				report_fail($sformatf("word with nothing expected: status %0d high %h low %h count %0d",
					got.status, got.found_high, got.found_low, got.entry_count));
			end else begin
				want = exp_q.pop_front();
				if (want.status !== got.status || want.found_high !== got.found_high ||
						want.found_low !== got.found_low || want.entry_count !== got.entry_count)
					report_fail($sformatf({"expected status %0d high %h low %h count %0d, ",
						"got status %0d high %h low %h count %0d"},
						want.status, want.found_high, want.found_low, want.entry_count,
						got.status, got.found_high, got.found_low, got.entry_count));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d cycles with no word moving", quiet_cycles);
				$display("FAIL variable_binding_table_core");
				$finish;
			end
		end
	end

	task automatic add_op(logic [2:0] op, logic [63:0] key, logic [63:0] hi, logic [63:0] lo,
			bit drain);
		binding_op_t it;
		it.op = op;
		it.label_key = key;
		it.value_high = hi;
		it.value_low = lo;
		it.drain_first = drain;
		pend_q.push_back(it);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// half full-width labels, half short names packed as bytes
	function automatic logic [63:0] rand_label();
		logic [63:0] k;
		int n;
		if ($urandom_range(0, 1))
			return rand_word();
		k = '0;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			k[63 - 8 * i -: 8] = 8'($urandom_range(97, 122));
		return k;
	endfunction

	function automatic logic [2:0] insert_op();
		return $urandom_range(0, 1) ? OP_BIND : OP_ADD;
	endfunction

	// clear, then a mix of inserts, lookups of held labels, misses, unknown ops and clears
	task automatic gen_session(int len, bit drain);
		logic [63:0] gk[$];
		logic [63:0] gh[$];
		logic [63:0] gl[$];
		logic [63:0] k;
		logic [63:0] h;
		logic [63:0] l;
		int r;
		int idx;
		add_op(OP_CLEAR, rand_word(), rand_word(), rand_word(), drain);
		for (int n = 0; n < len; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30 || (r < 75 && gk.size() == 0)) begin
				k = rand_label();
				h = rand_word();
				l = rand_word();
				add_op(insert_op(), k, h, l, 1'b0);
				if (gk.size() < TABLE_SLOTS) begin
					gk.push_back(k);
					gh.push_back(h);
					gl.push_back(l);
				end
			end else if (r < 75) begin
				idx = $urandom_range(0, gk.size() - 1);
				h = gh[idx];
				l = gl[idx];
				case ($urandom_range(0, 3))
					0: h ^= 64'd1 << $urandom_range(0, 63);
					1: l ^= 64'd1 << $urandom_range(0, 63);
					default: ;
				endcase
				add_op(3'($urandom_range(OP_BIND, OP_GET)), gk[idx], h, l, 1'b0);
			end else if (r < 90) begin
				add_op(3'($urandom_range(OP_BIND, OP_GET)), rand_label(), rand_word(),
					rand_word(), 1'b0);
			end else if (r < 96) begin
				add_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_word(), rand_word(),
					rand_word(), 1'b0);
			end else begin
				add_op(OP_CLEAR, rand_word(), rand_word(), rand_word(), 1'b0);
				gk.delete();
				gh.delete();
				gl.delete();
			end
		end
	endtask

	// fill every slot, hit the top one, then push inserts into the full table and look up a miss
	task automatic gen_fill(bit drain);
		logic [63:0] k;
		logic [63:0] h;
		logic [63:0] l;
		add_op(OP_CLEAR, rand_word(), rand_word(), rand_word(), drain);
		for (int n = 0; n < TABLE_SLOTS; n++) begin
			k = rand_word();
			h = rand_word();
			l = rand_word();
			add_op(insert_op(), k, h, l, 1'b0);
		end
		add_op(OP_GET, k, rand_word(), rand_word(), 1'b0);
		add_op(OP_BIND, k, h, l ^ 64'd1, 1'b0);
		add_op(OP_CHECK, k, h, l, 1'b0);
		repeat (3)
			add_op(insert_op(), rand_label(), rand_word(), rand_word(), 1'b0);
		add_op(OP_GET, rand_label(), rand_word(), rand_word(), 1'b0);
	endtask

	initial begin
		int n_directed;
		int fills;
		int r;
		int spare;
		req_ch.valid = 1'b0;
		req_ch.op = OP_BIND;
		req_ch.label_key = '0;
		req_ch.value_high = '0;
		req_ch.value_low = '0;
		rsp_ch.ready = 1'b0;

		add_op(OP_GET, '0, '0, '0, 1'b0);
		add_op(OP_CHECK, '1, '1, '1, 1'b0);
		add_op(OP_BIND, '1, '1, '1, 1'b0);
		add_op(OP_BIND, '1, '1, '1, 1'b0);
		add_op(OP_BIND, '1, 64'h7fff_ffff_ffff_ffff, '1, 1'b0);
		add_op(OP_BIND, '1, '1, 64'hffff_ffff_ffff_fffe, 1'b0);
		add_op(OP_CHECK, '1, '1, '1, 1'b0);
		add_op(OP_CHECK, '1, '0, '1, 1'b0);
		add_op(OP_ADD, '0, '0, '0, 1'b0);
		// held label: add ignores the differing value
		add_op(OP_ADD, '0, '1, '1, 1'b0);
		add_op(OP_GET, '1, '0, '0, 1'b0);
		add_op(OP_GET, '0, '1, '1, 1'b0);
		add_op(OP_ADD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555, 1'b0);
		add_op(OP_GET, 64'h5555_5555_5555_5555, '0, '0, 1'b0);
		add_op(OP_GET, 64'haaaa_aaaa_aaaa_aaaa, '0, '0, 1'b0);
		add_op(OP_SPARE_LO, '1, '1, '1, 1'b0);
		add_op(3'(OP_SPARE_LO + 1), '0, '0, '0, 1'b0);
		add_op(OP_SPARE_HI, '1, '1, '1, 1'b0);
		add_op(OP_CLEAR, '1, '1, '1, 1'b0);
		add_op(OP_GET, '1, '0, '0, 1'b0);
		add_op(OP_BIND, '1, '0, '0, 1'b0);
		add_op(OP_GET, '1, '1, '1, 1'b0);
		n_directed = pend_q.size();

		gen_fill(1'b1);
		fills = 1;
		while (pend_q.size() < ITEM_TARGET + n_directed) begin
			r = $urandom_range(0, 99);
			if (r < 4 && fills < 4) begin
				gen_fill($urandom_range(0, 3) == 0);
				fills++;
			end else begin
				gen_session((r < 15) ? $urandom_range(30, 45) : $urandom_range(3, 20),
					$urandom_range(0, 5) == 0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || req_ch.valid || exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exp_q.size() != 0)
			report_fail($sformatf("%0d results never arrived", exp_q.size()));

		spare = 0;
		for (int i = OP_SPARE_LO; i <= OP_SPARE_HI; i++)
			spare += op_seen[i];
		$display("ran %0d ops, %0d words: bind %0d, check %0d, add %0d, get %0d, clear %0d, spare %0d",
			n_acc, n_words, op_seen[OP_BIND], op_seen[OP_CHECK], op_seen[OP_ADD],
			op_seen[OP_GET], op_seen[OP_CLEAR], spare);
		$display("status ok %0d, conflict %0d, not found %0d, full %0d; %0d long holds, %0d failures",
			status_seen[ST_OK], status_seen[ST_CONFLICT], status_seen[ST_MISSING],
			status_seen[ST_FULL], n_holds, n_fail);
		if (n_fail == 0)
			$display("PASS variable_binding_table_core");
		else
			$display("FAIL variable_binding_table_core");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/vbt_pkg.sv
sv/vbt_req_if.sv
sv/vbt_rsp_if.sv
sv/vbt_ctrl.sv
sv/vbt_datapath.sv
sv/variable_binding_table_core.sv
bench/variable_binding_table_core_tb.sv
